>>> hdl/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

    localparam int TPS_W       = 16;
    localparam int ADDR_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BASE_ADDR  = 1'd1;

    localparam logic [TPS_W-1:0]  TPS_RESET  = 16'd100;
    localparam logic [ADDR_W-1:0] BASE_RESET = 7'd24;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5,
        PH_BD, PH_BH, PH_BL, PH_BR, PH_AH, PH_AS, PH_AL,
        PH_RH, PH_RS, PH_RL, PH_NR, PH_NH, PH_NL,
        PH_SP1, PH_SP2, PH_SP3
    } phase_t;

    typedef enum logic [1:0] {
        STG_ADDR_WR, STG_CMD, STG_DATA, STG_ADDR_RD
    } stage_t;

    typedef struct packed {
        logic [TPS_W-1:0]  ticks_per_step;
        logic [ADDR_W-1:0] device_base_address;
    } cfg_t;

    // Packed so that scl_level lands in bit 0 of the output word.
    typedef struct packed {
        logic [7:0] read_data;
        logic       no_ack_error;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } result_t;

endpackage

>>> hdl/i2cm_core.sv
// Transaction sequencer: pin state, step timer and byte shifter for one tick per word.
module i2cm_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic                   start_request,
    input  logic                   is_read,
    input  logic [2:0]             device_select,
    input  logic [7:0]             command_byte,
    input  logic [7:0]             write_data,
    input  logic                   sda_in,
    input  i2cm_pkg::cfg_t         cfg,
    output i2cm_pkg::result_t      result
);

    i2cm_pkg::phase_t              phase_reg, phase_next, eff_phase, tgt_phase;
    i2cm_pkg::stage_t              stage_reg, stage_next, eff_stage;
    logic [i2cm_pkg::TPS_W-1:0]    timer_reg, timer_next, eff_timer, timer_dec, tps_eff;
    logic [3:0]                    bit_reg, bit_next, eff_bit;
    logic [7:0]                    shift_reg, shift_next, eff_shift;
    logic [19:0]                   req_reg, req_next, eff_req;
    logic                          sda_reg, sda_next, eff_sda;
    logic                          scl_reg, scl_next, eff_scl;
    logic                          nack_reg, nack_next, eff_nack;
    logic                          active;
    logic                          enter_step;
    logic [i2cm_pkg::ADDR_W-1:0]   dev_addr;

    assign tps_eff  = (cfg.ticks_per_step == '0) ? {{(i2cm_pkg::TPS_W-1){1'b0}}, 1'b1}
                                                  : cfg.ticks_per_step;
    assign dev_addr = cfg.device_base_address + {4'b0, eff_req[18:16]};

    // Idle handling: take a new request or park the pins.
    always_comb
    begin
        eff_phase = phase_reg;
        eff_stage = stage_reg;
        eff_timer = timer_reg;
        eff_bit   = bit_reg;
        eff_shift = shift_reg;
        eff_req   = req_reg;
        eff_sda   = sda_reg;
        eff_scl   = scl_reg;
        eff_nack  = nack_reg;
        active    = 1'b1;
        if (phase_reg == i2cm_pkg::PH_IDLE)
        begin
            if (!start_request)
            begin
                active  = 1'b0;
                eff_scl = 1'b1;
                eff_sda = 1'b0;
            end
            else
            begin
                eff_req   = {is_read, device_select, command_byte, write_data};
                eff_stage = i2cm_pkg::STG_ADDR_WR;
                eff_nack  = 1'b0;
                eff_shift = 8'd0;
                eff_bit   = 4'd0;
                eff_phase = i2cm_pkg::PH_ST1;
                eff_timer = tps_eff;
                eff_sda   = 1'b0;
            end
        end
    end

    assign timer_dec = (eff_timer != '0) ? eff_timer - 1'b1 : eff_timer;

    // Step transitions and result word.
    always_comb
    begin
        phase_next = eff_phase;
        stage_next = eff_stage;
        timer_next = timer_dec;
        bit_next   = eff_bit;
        shift_next = eff_shift;
        req_next   = eff_req;
        sda_next   = eff_sda;
        scl_next   = eff_scl;
        nack_next  = eff_nack;
        tgt_phase  = eff_phase;
        enter_step = 1'b0;
        result     = '0;
        result.scl_level    = eff_scl;
        result.sda_pull_low = eff_sda;
        result.busy_res     = active;
        if (active && timer_dec == '0)
        begin
            enter_step = 1'b1;
            case (eff_phase)
                i2cm_pkg::PH_ST1: tgt_phase = i2cm_pkg::PH_ST2;
                i2cm_pkg::PH_ST2: tgt_phase = i2cm_pkg::PH_ST3;
                i2cm_pkg::PH_ST3: tgt_phase = i2cm_pkg::PH_ST4;
                i2cm_pkg::PH_ST4: tgt_phase = i2cm_pkg::PH_ST5;
                i2cm_pkg::PH_ST5:
                begin
                    shift_next = {dev_addr, (eff_stage == i2cm_pkg::STG_ADDR_RD)};
                    bit_next   = 4'd0;
                    tgt_phase  = i2cm_pkg::PH_BD;
                end
                i2cm_pkg::PH_BD: tgt_phase = i2cm_pkg::PH_BH;
                i2cm_pkg::PH_BH: tgt_phase = i2cm_pkg::PH_BL;
                i2cm_pkg::PH_BL:
                begin
                    shift_next = {eff_shift[6:0], 1'b0};
                    bit_next   = eff_bit + 4'd1;
                    tgt_phase  = (bit_next >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_BR
                                                                        : i2cm_pkg::PH_BD;
                end
                i2cm_pkg::PH_BR: tgt_phase = i2cm_pkg::PH_AH;
                i2cm_pkg::PH_AH: tgt_phase = i2cm_pkg::PH_AS;
                i2cm_pkg::PH_AS:
                begin
                    nack_next = eff_nack | sda_in;
                    tgt_phase = i2cm_pkg::PH_AL;
                end
                i2cm_pkg::PH_AL:
                begin
                    bit_next = 4'd0;
                    if (eff_nack)
                        tgt_phase = i2cm_pkg::PH_SP1;
                    else
                    begin
                        case (eff_stage)
                            i2cm_pkg::STG_ADDR_WR:
                            begin
                                stage_next = i2cm_pkg::STG_CMD;
                                shift_next = eff_req[15:8];
                                tgt_phase  = i2cm_pkg::PH_BD;
                            end
                            i2cm_pkg::STG_CMD:
                            begin
                                if (eff_req[19])
                                begin
                                    stage_next = i2cm_pkg::STG_ADDR_RD;
                                    tgt_phase  = i2cm_pkg::PH_ST1;
                                end
                                else
                                begin
                                    stage_next = i2cm_pkg::STG_DATA;
                                    shift_next = eff_req[7:0];
                                    tgt_phase  = i2cm_pkg::PH_BD;
                                end
                            end
                            i2cm_pkg::STG_ADDR_RD:
                            begin
                                shift_next = 8'd0;
                                tgt_phase  = i2cm_pkg::PH_RH;
                            end
                            default: tgt_phase = i2cm_pkg::PH_SP1;
                        endcase
                    end
                end
                i2cm_pkg::PH_RH: tgt_phase = i2cm_pkg::PH_RS;
                i2cm_pkg::PH_RS:
                begin
                    shift_next = {eff_shift[6:0], sda_in};
                    tgt_phase  = i2cm_pkg::PH_RL;
                end
                i2cm_pkg::PH_RL:
                begin
                    bit_next  = eff_bit + 4'd1;
                    tgt_phase = (bit_next >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_NR
                                                                       : i2cm_pkg::PH_RH;
                end
                i2cm_pkg::PH_NR:  tgt_phase = i2cm_pkg::PH_NH;
                i2cm_pkg::PH_NH:  tgt_phase = i2cm_pkg::PH_NL;
                i2cm_pkg::PH_NL:  tgt_phase = i2cm_pkg::PH_SP1;
                i2cm_pkg::PH_SP1: tgt_phase = i2cm_pkg::PH_SP2;
                i2cm_pkg::PH_SP2: tgt_phase = i2cm_pkg::PH_SP3;
                default:
                begin
                    // end of stop: drop back to idle and report
                    enter_step          = 1'b0;
                    phase_next          = i2cm_pkg::PH_IDLE;
                    timer_next          = '0;
                    result.busy_res     = 1'b0;
                    result.done_res     = 1'b1;
                    result.no_ack_error = eff_nack;
                    result.read_data    = (eff_req[19] && !eff_nack) ? eff_shift : 8'd0;
                end
            endcase
        end
        if (enter_step)
        begin
            phase_next = tgt_phase;
            timer_next = tps_eff;
            case (tgt_phase)
                i2cm_pkg::PH_ST1, i2cm_pkg::PH_ST5, i2cm_pkg::PH_BR, i2cm_pkg::PH_AS,
                i2cm_pkg::PH_RS, i2cm_pkg::PH_NR, i2cm_pkg::PH_SP3:
                    sda_next = 1'b0;
                i2cm_pkg::PH_ST3, i2cm_pkg::PH_SP1:
                    sda_next = 1'b1;
                i2cm_pkg::PH_ST2, i2cm_pkg::PH_BH, i2cm_pkg::PH_AH, i2cm_pkg::PH_RH,
                i2cm_pkg::PH_NH, i2cm_pkg::PH_SP2:
                    scl_next = 1'b1;
                i2cm_pkg::PH_ST4, i2cm_pkg::PH_BL, i2cm_pkg::PH_AL, i2cm_pkg::PH_RL,
                i2cm_pkg::PH_NL:
                    scl_next = 1'b0;
                i2cm_pkg::PH_BD:
                    sda_next = ~shift_next[7];
                default:
                    sda_next = sda_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cm_pkg::PH_IDLE;
            stage_reg <= i2cm_pkg::STG_ADDR_WR;
            timer_reg <= '0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            req_reg   <= 20'd0;
            sda_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            nack_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            req_reg   <= req_next;
            sda_reg   <= sda_next;
            scl_reg   <= scl_next;
            nack_reg  <= nack_next;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result.done_res) |-> !result.busy_res)
        else $error("done word reports busy");

    a_data_only_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result.read_data != 8'd0) |-> result.done_res)
        else $error("read data outside done word");

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_IDLE) |-> (timer_reg == '0))
        else $error("step timer running while idle");

    a_idle_lines_released: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_IDLE) |-> (scl_reg && !sda_reg))
        else $error("bus lines not at idle level while idle");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= i2cm_pkg::BITS_PER_BYTE)
        else $error("bit index past one byte");

endmodule

>>> hdl/i2cm_out_stage.sv
// Output register holding one result word until the receiver takes it.
module i2cm_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  i2cm_pkg::result_t   din,
    output logic                valid,
    input  logic                ready,
    output i2cm_pkg::result_t   dout
);

    logic               valid_reg, valid_next;
    i2cm_pkg::result_t  data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign valid = valid_reg;
    assign dout  = data_reg;

endmodule

>>> hdl/i2c_master_register_access.sv
// Top level of the tick-driven I2C register access master.
//
// Each input word is one tick: a request (start, read/write, device select,
// command byte, write byte) plus the sampled SDA level. Each accepted word
// yields exactly one output word with the SCL level and SDA pull-down to drive
// for that tick, busy, a done pulse, the no-acknowledge flag and the read byte.
// A transaction is latched from the first word with start_request set while
// idle; later requests are ignored until done has been reported.
// A word's result is registered and appears on the output in the cycle after
// the word is accepted. Throughput: one word per cycle when not stalled, set by
// the single step of sequencer logic between state and output registers.
// The input is ready whenever the output register is empty or is being taken,
// so a stalled receiver holds the result and stalls the input after one word.
// The config port writes ticks_per_step (index 0) and the seven-bit device
// base address (index 1) whenever cfg_wr_en is high.
// Reset puts the sequencer idle with SCL high, SDA released, an empty output
// register, ticks_per_step at 100 and the base address at 24.
module i2c_master_register_access (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_request, is_read, device_select[2:0], command_byte[7:0],
    // write_data[7:0], sda_in, zero pad
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // scl_level, sda_pull_low, busy_res, done_res, no_ack_error,
    // read_data[7:0], zero pad
    output logic [i2cm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    i2cm_pkg::cfg_t     cfg_reg;
    i2cm_pkg::result_t  core_result;
    i2cm_pkg::result_t  out_word;
    logic               accept;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_step      <= i2cm_pkg::TPS_RESET;
            cfg_reg.device_base_address <= i2cm_pkg::BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_TICKS_PER_STEP:
                    cfg_reg.ticks_per_step <= cfg_wdata;
                i2cm_pkg::CFG_DEVICE_BASE_ADDR:
                    cfg_reg.device_base_address <= cfg_wdata[i2cm_pkg::ADDR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    i2cm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (accept),
        .start_request (s_axis_tdata[0]),
        .is_read       (s_axis_tdata[1]),
        .device_select (s_axis_tdata[4:2]),
        .command_byte  (s_axis_tdata[12:5]),
        .write_data    (s_axis_tdata[20:13]),
        .sda_in        (s_axis_tdata[21]),
        .cfg           (cfg_reg),
        .result        (core_result)
    );

    i2cm_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .din   (core_result),
        .valid (m_axis_tvalid),
        .ready (m_axis_tready),
        .dout  (out_word)
    );

    assign m_axis_tdata = {{(i2cm_pkg::OUT_TDATA_W - $bits(i2cm_pkg::result_t)){1'b0}},
                           out_word};

endmodule

>>> sim/tb_i2c_master_register_access.sv
// Testbench for the I2C register access master: per-tick line prediction and result checks.
`timescale 1ns / 100ps

module tb_i2c_master_register_access;

    // One input word; the last field sits in the lowest bits.
    typedef struct packed {
        logic       sda;
        logic [7:0] wdata;
        logic [7:0] cmd;
        logic [2:0] sel;
        logic       rd;
        logic       start;
    } tick_t;

    localparam int TICK_W = $bits(tick_t);
    localparam int RES_W  = $bits(i2cm_pkg::result_t);
    localparam int IN_W   = i2cm_pkg::IN_TDATA_W;
    localparam int OUT_W  = i2cm_pkg::OUT_TDATA_W;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // start_request, is_read, device_select[2:0], command_byte[7:0],
    // write_data[7:0], sda_in, zero pad
    logic [IN_W-1:0]                    s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // scl_level, sda_pull_low, busy_res, done_res, no_ack_error,
    // read_data[7:0], zero pad
    logic [OUT_W-1:0]                   m_axis_tdata;
    logic                               cfg_wr_en = 1'b0;
    logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

    i2c_master_register_access dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Sequencer copy and its configuration
    logic [i2cm_pkg::TPS_W-1:0]  tick_len   = i2cm_pkg::TPS_RESET;
    logic [i2cm_pkg::ADDR_W-1:0] base_addr  = i2cm_pkg::BASE_RESET;
    i2cm_pkg::phase_t            seq_phase  = i2cm_pkg::PH_IDLE;
    logic [15:0]                 step_left  = '0;
    logic [3:0]                  bit_pos    = '0;
    logic [7:0]                  shifter    = '0;
    logic [19:0]                 held_req   = '0;
    logic                        sda_low    = 1'b0;
    logic                        scl_high   = 1'b1;
    i2cm_pkg::stage_t            byte_kind  = i2cm_pkg::STG_ADDR_WR;
    logic                        saw_nack   = 1'b0;

    i2cm_pkg::result_t expected_words[$];
    int      fail_count     = 0;
    int      ticks_sent     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_left      = 0;

    // How the slave side answers the current transaction
    int          txn_nack_stage = -1;
    logic [7:0]  txn_pattern    = '0;
    bit          txn_noise      = 1'b0;
    bit          txn_busy_req   = 1'b0;

    function automatic logic [7:0] address_word(input logic rw);
        logic [i2cm_pkg::ADDR_W-1:0] a;
        a = base_addr + {4'b0, held_req[18:16]};
        return {a, rw};
    endfunction

    function automatic void enter_step(input i2cm_pkg::phase_t p);
        seq_phase = p;
        step_left = (tick_len == '0) ? 16'd1 : tick_len;
        case (p)
            i2cm_pkg::PH_ST1, i2cm_pkg::PH_ST5, i2cm_pkg::PH_BR, i2cm_pkg::PH_AS,
            i2cm_pkg::PH_RS, i2cm_pkg::PH_NR, i2cm_pkg::PH_SP3:
                sda_low = 1'b0;
            i2cm_pkg::PH_ST3, i2cm_pkg::PH_SP1:
                sda_low = 1'b1;
            i2cm_pkg::PH_ST2, i2cm_pkg::PH_BH, i2cm_pkg::PH_AH, i2cm_pkg::PH_RH,
            i2cm_pkg::PH_NH, i2cm_pkg::PH_SP2:
                scl_high = 1'b1;
            i2cm_pkg::PH_ST4, i2cm_pkg::PH_BL, i2cm_pkg::PH_AL, i2cm_pkg::PH_RL,
            i2cm_pkg::PH_NL:
                scl_high = 1'b0;
            i2cm_pkg::PH_BD:
                sda_low = ~shifter[7];
            default: ;
        endcase
    endfunction

    // Close the current step; return 1 when the transaction is over.
    function automatic bit end_step(input logic sda);
        bit over;
        over = 1'b0;
        case (seq_phase)
            i2cm_pkg::PH_ST1: enter_step(i2cm_pkg::PH_ST2);
            i2cm_pkg::PH_ST2: enter_step(i2cm_pkg::PH_ST3);
            i2cm_pkg::PH_ST3: enter_step(i2cm_pkg::PH_ST4);
            i2cm_pkg::PH_ST4: enter_step(i2cm_pkg::PH_ST5);
            i2cm_pkg::PH_ST5:
            begin
                shifter = address_word(byte_kind == i2cm_pkg::STG_ADDR_RD);
                bit_pos = '0;
                enter_step(i2cm_pkg::PH_BD);
            end
            i2cm_pkg::PH_BD: enter_step(i2cm_pkg::PH_BH);
            i2cm_pkg::PH_BH: enter_step(i2cm_pkg::PH_BL);
            i2cm_pkg::PH_BL:
            begin
                shifter = shifter << 1;
                bit_pos = bit_pos + 4'd1;
                if (bit_pos >= i2cm_pkg::BITS_PER_BYTE)
                    enter_step(i2cm_pkg::PH_BR);
                else
                    enter_step(i2cm_pkg::PH_BD);
            end
            i2cm_pkg::PH_BR: enter_step(i2cm_pkg::PH_AH);
            i2cm_pkg::PH_AH: enter_step(i2cm_pkg::PH_AS);
            i2cm_pkg::PH_AS:
            begin
                if (sda)
                    saw_nack = 1'b1;
                enter_step(i2cm_pkg::PH_AL);
            end
            i2cm_pkg::PH_AL:
            begin
                bit_pos = '0;
                if (saw_nack)
                    enter_step(i2cm_pkg::PH_SP1);
                else
                begin
                    case (byte_kind)
                        i2cm_pkg::STG_ADDR_WR:
                        begin
                            byte_kind = i2cm_pkg::STG_CMD;
                            shifter = held_req[15:8];
                            enter_step(i2cm_pkg::PH_BD);
                        end
                        i2cm_pkg::STG_CMD:
                        begin
                            if (held_req[19])
                            begin
                                byte_kind = i2cm_pkg::STG_ADDR_RD;
                                enter_step(i2cm_pkg::PH_ST1);
                            end
                            else
                            begin
                                byte_kind = i2cm_pkg::STG_DATA;
                                shifter = held_req[7:0];
                                enter_step(i2cm_pkg::PH_BD);
                            end
                        end
                        i2cm_pkg::STG_ADDR_RD:
                        begin
                            shifter = '0;
                            enter_step(i2cm_pkg::PH_RH);
                        end
                        default: enter_step(i2cm_pkg::PH_SP1);
                    endcase
                end
            end
            i2cm_pkg::PH_RH: enter_step(i2cm_pkg::PH_RS);
            i2cm_pkg::PH_RS:
            begin
                shifter = {shifter[6:0], sda};
                enter_step(i2cm_pkg::PH_RL);
            end
            i2cm_pkg::PH_RL:
            begin
                bit_pos = bit_pos + 4'd1;
                if (bit_pos >= i2cm_pkg::BITS_PER_BYTE)
                    enter_step(i2cm_pkg::PH_NR);
                else
                    enter_step(i2cm_pkg::PH_RH);
            end
            i2cm_pkg::PH_NR:  enter_step(i2cm_pkg::PH_NH);
            i2cm_pkg::PH_NH:  enter_step(i2cm_pkg::PH_NL);
            i2cm_pkg::PH_NL:  enter_step(i2cm_pkg::PH_SP1);
            i2cm_pkg::PH_SP1: enter_step(i2cm_pkg::PH_SP2);
            i2cm_pkg::PH_SP2: enter_step(i2cm_pkg::PH_SP3);
            default:
            begin
                seq_phase = i2cm_pkg::PH_IDLE;
                step_left = '0;
                over = 1'b1;
            end
        endcase
        return over;
    endfunction

    // Line levels and status expected for one tick.
    function automatic i2cm_pkg::result_t step_sequencer(input tick_t t);
        i2cm_pkg::result_t r;
        r = '0;
        if (seq_phase == i2cm_pkg::PH_IDLE)
        begin
            if (!t.start)
            begin
                scl_high = 1'b1;
                sda_low = 1'b0;
                r.scl_level = 1'b1;
                return r;
            end
            held_req = {t.rd, t.sel, t.cmd, t.wdata};
            byte_kind = i2cm_pkg::STG_ADDR_WR;
            saw_nack = 1'b0;
            shifter = '0;
            bit_pos = '0;
            enter_step(i2cm_pkg::PH_ST1);
        end
        r.scl_level = scl_high;
        r.sda_pull_low = sda_low;
        r.busy_res = 1'b1;
        if (step_left != '0)
            step_left = step_left - 16'd1;
        if (step_left == '0)
        begin
            if (end_step(t.sda))
            begin
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                r.no_ack_error = saw_nack;
                r.read_data = (held_req[19] && !saw_nack) ? shifter : 8'd0;
            end
        end
        return r;
    endfunction

    function automatic tick_t random_tick();
        logic [TICK_W-1:0] raw;
        raw = TICK_W'($urandom);
        return raw;
    endfunction

    always @(posedge clk)
    begin : recv_ready
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        i2cm_pkg::result_t got;
        i2cm_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[RES_W-1:0];
            if (expected_words.size() == 0)
            begin
                $error("result word %0h with nothing expected", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
                check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got.sda_pull_low));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("no_ack_error", 8'(want.no_ack_error), 8'(got.no_ack_error));
                check_field("read_data", want.read_data, got.read_data);
                check_field("pad", 8'd0, 8'(m_axis_tdata[OUT_W-1:RES_W]));
            end
        end
    end

    task automatic send_tick(input tick_t t);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(t);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_words.push_back(step_sequencer(t));
        ticks_sent++;
    endtask

    // Drop valid and wait for every outstanding word.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [i2cm_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == i2cm_pkg::CFG_TICKS_PER_STEP)
            tick_len = val;
        else
            base_addr = val[i2cm_pkg::ADDR_W-1:0];
    endtask

    task automatic set_txn(input int nack_stage, input logic [7:0] pattern,
                           input bit noise, input bit busy_req);
        txn_nack_stage = nack_stage;
        txn_pattern = pattern;
        txn_noise = noise;
        txn_busy_req = busy_req;
    endtask

    task automatic idle_ticks(input int n);
        tick_t t;
        repeat (n)
        begin
            t = random_tick();
            t.start = 1'b0;
            send_tick(t);
        end
    endtask

    task automatic begin_txn(input logic rd, input logic [2:0] sel,
                             input logic [7:0] cmd, input logic [7:0] wdata);
        tick_t t;
        t = random_tick();
        t.start = 1'b1;
        t.rd = rd;
        t.sel = sel;
        t.cmd = cmd;
        t.wdata = wdata;
        send_tick(t);
    endtask

    // Play the slave side until the transaction ends or the limit is hit.
    task automatic run_ticks(input int limit);
        tick_t t;
        int    n;
        n = 0;
        while (seq_phase != i2cm_pkg::PH_IDLE && (limit == 0 || n < limit))
        begin
            t = random_tick();
            t.start = txn_busy_req;
            if (seq_phase == i2cm_pkg::PH_AS && !txn_noise)
                t.sda = (int'(byte_kind) == txn_nack_stage);
            else if (seq_phase == i2cm_pkg::PH_RS)
                t.sda = txn_pattern[7 - bit_pos];
            send_tick(t);
            n++;
        end
    endtask

    task automatic run_txn(input logic rd, input logic [2:0] sel,
                           input logic [7:0] cmd, input logic [7:0] wdata);
        begin_txn(rd, sel, cmd, wdata);
        run_ticks(0);
    endtask

    task automatic test_idle_level();
        idle_ticks(6);
    endtask

    // Default step length on the opening step, then finish at one tick per step.
    task automatic test_reset_config();
        set_txn(-1, 8'h00, 1'b0, 1'b0);
        begin_txn(1'b0, 3'd7, 8'hFF, 8'h00);
        run_ticks(98);
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd1);
        run_ticks(0);
    endtask

    task automatic test_write_extremes();
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd1);
        set_txn(-1, 8'h00, 1'b0, 1'b0);
        run_txn(1'b0, 3'd0, 8'h00, 8'hFF);
    endtask

    task automatic test_read();
        set_txn(-1, 8'hA5, 1'b0, 1'b0);
        run_txn(1'b1, 3'd5, 8'h3C, 8'hFF);
    endtask

    // One missing acknowledge in each byte position.
    task automatic test_nack();
        set_txn(int'(i2cm_pkg::STG_ADDR_WR), 8'h5A, 1'b0, 1'b0);
        run_txn(1'b0, 3'd1, 8'h55, 8'hAA);
        set_txn(int'(i2cm_pkg::STG_CMD), 8'h5A, 1'b0, 1'b0);
        run_txn(1'b1, 3'd2, 8'hAA, 8'h55);
        set_txn(int'(i2cm_pkg::STG_DATA), 8'h5A, 1'b0, 1'b0);
        run_txn(1'b0, 3'd3, 8'h0F, 8'hF0);
        set_txn(int'(i2cm_pkg::STG_ADDR_RD), 8'h5A, 1'b0, 1'b0);
        run_txn(1'b1, 3'd4, 8'hF0, 8'h0F);
    endtask

    // Hold start high on every tick, done tick included, then go back to back.
    task automatic test_busy_request();
        set_txn(-1, 8'hC3, 1'b0, 1'b1);
        run_txn(1'b0, 3'd6, 8'h81, 8'h18);
        set_txn(int'(i2cm_pkg::STG_ADDR_WR), 8'hC3, 1'b0, 1'b1);
        run_txn(1'b1, 3'd1, 8'h18, 8'h81);
        idle_ticks(2);
    endtask

    task automatic test_addr_wrap();
        drain();
        write_reg(i2cm_pkg::CFG_DEVICE_BASE_ADDR, 16'hFFFF);
        set_txn(int'(i2cm_pkg::STG_CMD), 8'h96, 1'b0, 1'b0);
        run_txn(1'b0, 3'd7, 8'h01, 8'h80);
        set_txn(int'(i2cm_pkg::STG_ADDR_RD), 8'h96, 1'b0, 1'b0);
        run_txn(1'b1, 3'd1, 8'h02, 8'h40);
        drain();
        write_reg(i2cm_pkg::CFG_DEVICE_BASE_ADDR, 16'h0000);
        set_txn(int'(i2cm_pkg::STG_ADDR_WR), 8'h96, 1'b0, 1'b0);
        run_txn(1'b1, 3'd0, 8'h7F, 8'hFE);
    endtask

    task automatic test_step_lengths();
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd0);
        set_txn(int'(i2cm_pkg::STG_ADDR_WR), 8'h69, 1'b0, 1'b0);
        run_txn(1'b0, 3'd2, 8'hE7, 8'h7E);
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd3);
        run_txn(1'b1, 3'd3, 8'h7E, 8'hE7);
    endtask

    // Long step, with both registers changed while the transfer runs.
    task automatic test_long_step();
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd30);
        set_txn(-1, 8'h3A, 1'b0, 1'b0);
        begin_txn(1'b1, 3'd2, 8'h81, 8'h7E);
        run_ticks(10);
        drain();
        write_reg(i2cm_pkg::CFG_DEVICE_BASE_ADDR, 16'd5);
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'd1);
        run_ticks(0);
    endtask

    task automatic test_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_txn(-1, 8'($urandom), 1'b0, 1'b0);
        hold_left = 300;
        begin_txn(1'b0, 3'($urandom), 8'($urandom), 8'($urandom));
        run_ticks(40);
        drain();
        run_ticks(0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int target;
        int nack_stage;
        drain();
        write_reg(i2cm_pkg::CFG_TICKS_PER_STEP, 16'($urandom_range(0, 1)));
        write_reg(i2cm_pkg::CFG_DEVICE_BASE_ADDR, 16'($urandom));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = ticks_sent + n;
        while (ticks_sent < target)
        begin
            idle_ticks($urandom_range(0, 3));
            nack_stage = ($urandom_range(99) < 10) ? int'($urandom_range(0, 3)) : -1;
            set_txn(nack_stage, 8'($urandom), $urandom_range(99) < 15,
                    1'($urandom_range(1)));
            run_txn(1'($urandom_range(1)), 3'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_level();
        test_reset_config();
        test_write_extremes();
        test_read();
        test_nack();
        test_busy_request();
        test_addr_wrap();
        test_step_lengths();
        test_long_step();
        test_pressure();
        test_random_traffic(0, 0, 100);
        test_random_traffic(45, 0, 100);
        test_random_traffic(0, 45, 100);
        test_random_traffic(15, 15, 100);
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
